// ----- sv/mlh_pkg.sv -----
// ---------------------------------------------------------------------------
// mlh_pkg: shared types and constants for the lower-case MurmurHash2 block
// Mixing constants, queue entry layout and back-end sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package mlh_pkg;

   // Hash constants
   localparam logic [31:0] MIX_MULT    = 32'h5bd1e995;
   localparam int unsigned MIX_SHIFT   = 24;
   localparam int unsigned FIN_SHIFT_A = 13;
   localparam int unsigned FIN_SHIFT_B = 15;
   localparam logic [31:0] SEED_RESET  = 32'h31415926;

   // Queue between front and back (power of two, at least 2)
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // One unit of work for the back end
   typedef struct packed {
      logic        start;     // load accumulator from init_val first
      logic [31:0] init_val;  // seed XOR message length
      logic        mix_word;  // data is a full word to mix
      logic        mix_tail;  // data holds one to three tail bytes
      logic        finish;    // run the avalanche and emit a hash
      logic [31:0] data;
   } mlh_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_K1,
      S_K2,
      S_HM,
      S_TAIL,
      S_AVAL
   } mlh_state_type;

endpackage

`default_nettype wire

// ----- sv/mlh_if.sv -----
// ---------------------------------------------------------------------------
// mlh_if: valid/ready channels of the lower-case MurmurHash2 block
// Request channel carries message bytes, response channel carries hashes.
// ---------------------------------------------------------------------------
`default_nettype none

interface mlh_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [15:0] message_length;
   logic        last_byte;

   modport source (output valid, data_byte, message_length, last_byte, input ready);
   modport sink   (input valid, data_byte, message_length, last_byte, output ready);
endinterface

interface mlh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

// ----- sv/murmur2_lowercase_hash.sv -----
// ---------------------------------------------------------------------------
// murmur2_lowercase_hash: case-insensitive 32-bit MurmurHash2 over a byte stream
// Top level: seed register, byte intake, work queue and hash engine.
// ---------------------------------------------------------------------------
// Send one byte per word; message_length is sampled on the first byte of a
// message and last_byte marks its end (a first word with length zero is an
// empty message by itself). The intake takes a byte every clock while the
// work queue has room. The hash engine shares one 32x32 constant multiplier:
// each entry is loaded in S_IDLE, a full four-byte word then passes S_K1,
// S_K2 and S_HM, a tail S_TAIL and the final avalanche S_AVAL. Long
// messages sustain one byte per clock; each message end adds the tail
// and avalanche states, and a hash waiting at the output holds the engine
// until it is taken. csr_write_data loads the seed.
`default_nettype none

module murmur2_lowercase_hash #(
   parameter int unsigned QUEUE_DEPTH = mlh_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mlh_req_if.sink          req_bus,
   mlh_rsp_if.source        rsp_bus,
   input  wire logic        csr_write_en,
   input  wire logic [31:0] csr_write_data
);
   import mlh_pkg::*;

   logic [31:0] seed_ff;
   logic        q_full;
   logic        q_push;
   mlh_op_type  q_push_op;
   logic        q_pop;
   mlh_op_type  q_head_op;
   logic        q_head_valid;

   // Seed register
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else if (csr_write_en) begin
         seed_ff <= csr_write_data;
      end
   end

   mlh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .seed       (seed_ff),
      .queue_full (q_full),
      .push       (q_push),
      .push_op    (q_push_op)
   );

   mlh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (q_push_op),
      .full       (q_full),
      .pop        (q_pop),
      .head_op    (q_head_op),
      .head_valid (q_head_valid)
   );

   mlh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_op    (q_head_op),
      .head_valid (q_head_valid),
      .pop        (q_pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- sv/mlh_front.sv -----
// ---------------------------------------------------------------------------
// mlh_front: byte intake
// Folds upper case, packs bytes little-endian into words and posts work
// entries (start, word, tail, finish) to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module mlh_front (
   input  wire logic               clock,
   input  wire logic               reset,
   mlh_req_if.sink                 req_bus,
   input  wire logic [31:0]        seed,
   input  wire logic               queue_full,
   output logic                    push,
   output mlh_pkg::mlh_op_type     push_op
);
   import mlh_pkg::*;

   logic        in_msg_ff, in_msg_in;
   logic [23:0] pend_ff, pend_in;
   logic [1:0]  cnt_ff, cnt_in;

   logic        accept;
   logic [7:0]  folded;
   logic [23:0] pend_eff;
   logic [1:0]  cnt_eff;
   logic [23:0] pend_new;
   logic        is_empty;
   mlh_op_type  op;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;

   // Fold ASCII A-Z to lower case
   always_comb begin
      folded = req_bus.data_byte;
      if (req_bus.data_byte inside {[8'h41:8'h5a]}) begin
         folded = req_bus.data_byte + 8'h20;
      end
   end

   // Classify the byte and build the work entry
   always_comb begin
      is_empty = !in_msg_ff && (req_bus.message_length == 16'd0);
      pend_eff = in_msg_ff ? pend_ff : 24'd0;
      cnt_eff  = in_msg_ff ? cnt_ff  : 2'd0;

      case (cnt_eff)
         2'd0:    pend_new = {16'd0, folded};
         2'd1:    pend_new = {8'd0, folded, pend_eff[7:0]};
         2'd2:    pend_new = {folded, pend_eff[15:0]};
         default: pend_new = pend_eff;
      endcase

      op          = '0;
      op.start    = !in_msg_ff;
      op.init_val = seed ^ {16'd0, req_bus.message_length};
      in_msg_in   = in_msg_ff;
      pend_in     = pend_ff;
      cnt_in      = cnt_ff;

      if (is_empty) begin
         op.finish = 1'b1;
      end else begin
         in_msg_in = 1'b1;
         if (cnt_eff == 2'd3) begin
            op.mix_word = 1'b1;
            op.data     = {folded, pend_eff};
            pend_in     = 24'd0;
            cnt_in      = 2'd0;
         end else begin
            op.data = {8'd0, pend_new};
            pend_in = pend_new;
            cnt_in  = cnt_eff + 2'd1;
         end
         if (req_bus.last_byte) begin
            op.finish   = 1'b1;
            op.mix_tail = (cnt_eff != 2'd3);
            in_msg_in   = 1'b0;
            pend_in     = 24'd0;
            cnt_in      = 2'd0;
         end
      end
   end

   assign push    = accept && (op.start || op.mix_word || op.finish);
   assign push_op = op;

   // Advance message state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         pend_ff   <= 24'd0;
         cnt_ff    <= 2'd0;
      end else if (accept) begin
         in_msg_ff <= in_msg_in;
         pend_ff   <= pend_in;
         cnt_ff    <= cnt_in;
      end
   end

   // A finished message leaves no partial word behind
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.last_byte) |=> (!in_msg_ff && cnt_ff == 2'd0))
      else $error("front: message state not cleared after last byte");

endmodule

`default_nettype wire

// ----- sv/mlh_queue.sv -----
// ---------------------------------------------------------------------------
// mlh_queue: work queue between intake and hash engine
// Small first-in first-out buffer of work entries.
// ---------------------------------------------------------------------------
`default_nettype none

module mlh_queue #(
   parameter int unsigned DEPTH = mlh_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  mlh_pkg::mlh_op_type     push_op,
   output logic                    full,
   input  wire logic               pop,
   output mlh_pkg::mlh_op_type     head_op,
   output logic                    head_valid
);
   import mlh_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   mlh_op_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("queue: count above depth");

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue: push while full");

endmodule

`default_nettype wire

// ----- sv/mlh_back.sv -----
// ---------------------------------------------------------------------------
// mlh_back: hash engine
// Runs queued work entries through one shared constant multiplier:
// word mix, tail mix and final avalanche, then holds the hash for output.
// ---------------------------------------------------------------------------
`default_nettype none

module mlh_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  mlh_pkg::mlh_op_type     head_op,
   input  wire logic               head_valid,
   output logic                    pop,
   mlh_rsp_if.source               rsp_bus
);
   import mlh_pkg::*;

   mlh_state_type state_ff, state_in;
   logic [31:0]   acc_ff, acc_in;
   logic [31:0]   k_ff, k_in;
   logic          finish_ff, finish_in;
   logic [31:0]   hash_ff, hash_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          slot_free;
   logic [31:0]   mul_a;
   logic [31:0]   product;

   assign slot_free          = !rsp_valid_ff || rsp_bus.ready;
   assign product            = mul_a * MIX_MULT;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hash_value = hash_ff;

   // Sequencer: next state, multiplier operand and register updates
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      k_in         = k_ff;
      finish_in    = finish_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      pop          = 1'b0;
      mul_a        = k_ff;

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop       = 1'b1;
               k_in      = head_op.data;
               finish_in = head_op.finish;
               if (head_op.start) begin
                  acc_in = head_op.init_val;
               end
               if (head_op.mix_word) begin
                  state_in = S_K1;
               end else if (head_op.mix_tail) begin
                  state_in = S_TAIL;
               end else if (head_op.finish) begin
                  state_in = S_AVAL;
               end
            end
         end
         S_K1: begin
            mul_a    = k_ff;
            k_in     = product ^ (product >> MIX_SHIFT);
            state_in = S_K2;
         end
         S_K2: begin
            mul_a    = k_ff;
            k_in     = product;
            state_in = S_HM;
         end
         S_HM: begin
            mul_a    = acc_ff;
            acc_in   = product ^ k_ff;
            state_in = finish_ff ? S_AVAL : S_IDLE;
         end
         S_TAIL: begin
            mul_a    = acc_ff ^ k_ff;
            acc_in   = product;
            state_in = S_AVAL;
         end
         S_AVAL: begin
            mul_a = acc_ff ^ (acc_ff >> FIN_SHIFT_A);
            if (slot_free) begin
               hash_in      = product ^ (product >> FIN_SHIFT_B);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         finish_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         finish_ff    <= finish_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      k_ff    <= k_in;
      hash_ff <= hash_in;
   end

   // Hold the avalanche while the held hash is not taken
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AVAL && rsp_valid_ff && !rsp_bus.ready) |=> (state_ff == S_AVAL))
      else $error("back: avalanche overwrote a pending hash");

   // Take work only between entries
   assert property (@(posedge clock) disable iff (reset) pop |-> (state_ff == S_IDLE))
      else $error("back: entry popped while busy");

endmodule

`default_nettype wire

// ----- dv/murmur2_lowercase_hash_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// murmur2_lowercase_hash_tb: regression for the lower-case MurmurHash2 block
// Streams directed and random messages byte by byte, predicts each hash with
// a local model of the seed, word packing, tail mixing and avalanche, and
// checks every hash word in order, with both channels idling at random in most tests.
// ---------------------------------------------------------------------------

module murmur2_lowercase_hash_tb;

   import mlh_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [31:0] csr_write_data;

   mlh_req_if req_bus ();
   mlh_rsp_if rsp_bus ();

   murmur2_lowercase_hash dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Model state
   logic [31:0] seed_model;
   logic [31:0] running_hash;
   logic [23:0] gathered_bytes;
   logic [1:0]  gathered_count;
   logic        in_message;
   logic [31:0] expected_hashes[$];

   bit idle_enable;
   int fail_count;
   int bytes_sent;
   int messages_sent;
   int hashes_checked;
   int seeds_written;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Give up after a generous fixed time
   initial begin
      #10_000_000;
      $display("murmur2_lowercase_hash regression: fail");
      $finish;
   end

   function automatic logic [31:0] avalanche_hash(input logic [31:0] h);
      logic [31:0] v;
      v = h ^ (h >> FIN_SHIFT_A);
      v = v * MIX_MULT;
      v = v ^ (v >> FIN_SHIFT_B);
      return v;
   endfunction

   // Fold case, absorb one byte and queue the hash when a message ends
   task automatic absorb_byte(input logic [7:0] data, input logic [15:0] len,
                              input logic last);
      logic [7:0]  b;
      logic [31:0] h;
      logic [31:0] k;
      b = data;
      if (b >= 8'h41 && b <= 8'h5A) begin
         b = b + 8'h20;
      end
      if (!in_message) begin
         if (len == 16'd0) begin
            // empty message: data and last are ignored
            expected_hashes.push_back(avalanche_hash(seed_model));
            messages_sent++;
            return;
         end
         running_hash   = seed_model ^ {16'd0, len};
         gathered_bytes = '0;
         gathered_count = '0;
         in_message     = 1'b1;
      end
      h = running_hash;
      if (gathered_count == 2'd3) begin
         k = {b, gathered_bytes};
         k = k * MIX_MULT;
         k = k ^ (k >> MIX_SHIFT);
         k = k * MIX_MULT;
         h = h * MIX_MULT;
         h = h ^ k;
         gathered_bytes = '0;
         gathered_count = '0;
      end else begin
         gathered_bytes[8*gathered_count +: 8] = b;
         gathered_count = gathered_count + 2'd1;
      end
      running_hash = h;
      if (last) begin
         if (gathered_count != 2'd0) begin
            h = h ^ {8'd0, gathered_bytes};
            h = h * MIX_MULT;
         end
         expected_hashes.push_back(avalanche_hash(h));
         messages_sent++;
         running_hash   = '0;
         gathered_bytes = '0;
         gathered_count = '0;
         in_message     = 1'b0;
      end
   endtask

   // Offer one byte word, idling first at random, and hold it until taken
   task automatic send_byte(input logic [7:0] data, input logic [15:0] len,
                            input logic last);
      while (idle_enable && $urandom_range(99) < 13) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.data_byte      <= data;
      req_bus.message_length <= len;
      req_bus.last_byte      <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      absorb_byte(data, len, last);
      bytes_sent++;
   endtask

   // Drop valid, wait for every pending hash, then let the engine settle
   task automatic drain_hashes();
      req_bus.valid <= 1'b0;
      while (expected_hashes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      drain_hashes();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      seed_model = value;
      seeds_written++;
   endtask

   // Bias toward letters and the edges of the upper- and lower-case ranges
   function automatic logic [7:0] random_byte();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 25) begin
         return 8'h41 + 8'($urandom_range(25));
      end else if (r < 45) begin
         return 8'h61 + 8'($urandom_range(25));
      end else if (r < 52) begin
         case ($urandom_range(3))
            0: return 8'h40;
            1: return 8'h5B;
            2: return 8'h60;
            default: return 8'h7B;
         endcase
      end
      return 8'($urandom_range(255));
   endfunction

   task automatic send_message(input int n, input logic [15:0] len_field);
      for (int i = 0; i < n; i++) begin
         send_byte(random_byte(), (i == 0) ? len_field : 16'($urandom_range(65535)),
                   i == n - 1);
      end
   endtask

   task automatic test_empty_messages();
      send_byte(8'hFF, 16'd0, 1'b0);
      send_byte(8'h41, 16'd0, 1'b1);
   endtask

   task automatic test_case_folding();
      send_byte(8'h40, 16'd1, 1'b1);
      send_byte(8'h5B, 16'd1, 1'b1);
      // one full word, no tail
      send_byte(8'h41, 16'd4, 1'b0);
      send_byte(8'h5A, 16'd0, 1'b0);
      send_byte(8'h61, 16'd0, 1'b0);
      send_byte(8'h7A, 16'd0, 1'b1);
      // two-byte tail
      send_byte(8'h51, 16'd2, 1'b0);
      send_byte(8'h78, 16'hFFFF, 1'b1);
   endtask

   task automatic test_length_mismatch();
      // claimed length far above what is sent, one-byte tail
      send_byte(8'hFF, 16'hFFFF, 1'b0);
      send_byte(8'h00, 16'h0000, 1'b0);
      send_byte(8'h41, 16'hA5A5, 1'b0);
      send_byte(8'h5A, 16'h5A5A, 1'b0);
      send_byte(8'h80, 16'hFFFF, 1'b1);
      // claimed length below what is sent, three-byte tail
      send_byte(8'h48, 16'd2, 1'b0);
      send_byte(8'h65, 16'h8000, 1'b0);
      send_byte(8'h4C, 16'h0001, 1'b0);
      send_byte(8'h6C, 16'h7FFF, 1'b0);
      send_byte(8'h4F, 16'h0000, 1'b0);
      send_byte(8'h20, 16'hFFFF, 1'b0);
      send_byte(8'h57, 16'h1234, 1'b1);
   endtask

   task automatic test_seed_extremes();
      write_seed(32'h0000_0000);
      send_byte(8'h00, 16'd0, 1'b1);
      send_byte(8'h4D, 16'd1, 1'b1);
      write_seed(32'hFFFF_FFFF);
      send_byte(8'hFF, 16'd0, 1'b0);
      send_byte(8'hC3, 16'hFFFF, 1'b1);
   endtask

   // Mostly well-formed messages of random content and length
   task automatic test_random_stream(input int target);
      int stop_at;
      int unsigned kind;
      int n;
      stop_at = bytes_sent + target;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            send_byte(random_byte(), 16'd0, 1'($urandom_range(1)));
         end else if (kind < 20) begin
            n = $urandom_range(12, 1);
            send_message(n, 16'($urandom_range(65535, 1)));
         end else if (kind < 24) begin
            n = $urandom_range(80, 40);
            send_message(n, 16'(n));
         end else begin
            n = $urandom_range(12, 1);
            send_message(n, 16'(n));
         end
      end
   endtask

   // Check each hash word against the oldest prediction; stall at random
   initial begin
      logic [31:0] want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_hashes.size() == 0) begin
               $error("hash_value: expected none, got %h", rsp_bus.hash_value);
               fail_count++;
            end else begin
               want = expected_hashes.pop_front();
               hashes_checked++;
               if (rsp_bus.hash_value !== want) begin
                  $error("hash_value: expected %h, got %h", want, rsp_bus.hash_value);
                  fail_count++;
               end
            end
         end
         rsp_bus.ready <= !(idle_enable && $urandom_range(99) < 13);
      end
   end

   initial begin
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.data_byte      <= '0;
      req_bus.message_length <= '0;
      req_bus.last_byte      <= 1'b0;
      csr_write_en           <= 1'b0;
      csr_write_data         <= '0;
      idle_enable    = 1'b1;
      fail_count     = 0;
      bytes_sent     = 0;
      messages_sent  = 0;
      hashes_checked = 0;
      seeds_written  = 0;
      seed_model     = SEED_RESET;
      running_hash   = '0;
      gathered_bytes = '0;
      gathered_count = '0;
      in_message     = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_messages();
      test_case_folding();
      test_length_mismatch();
      test_seed_extremes();

      // long stretch with no idling on either side
      write_seed(32'($urandom()));
      idle_enable = 1'b0;
      test_random_stream(360);
      write_seed(32'($urandom()));
      idle_enable = 1'b1;
      test_random_stream(360);
      write_seed(32'h0000_0000);
      test_random_stream(360);
      write_seed(SEED_RESET);
      test_random_stream(370);

      drain_hashes();
      repeat (10) @(posedge clock);
      $display("Sent %0d bytes in %0d messages under %0d seed writes;",
               bytes_sent, messages_sent, seeds_written);
      $display("checked %0d hashes, %0d mismatches.", hashes_checked, fail_count);
      if (fail_count == 0) begin
         $display("murmur2_lowercase_hash regression: pass");
      end else begin
         $display("murmur2_lowercase_hash regression: fail");
      end
      $finish;
   end

endmodule
